FILE: rtl/satq_pkg.sv
// Package for the sorted alarm time queue.
// Holds sizes, operation and status codes, payload structs and cell control types.
// No dependencies.
`default_nettype none

package satq_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int TIME_W      = 31;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int OUT_CNT_W   = 7;

	typedef enum logic [1:0] {
		OP_ADD     = 2'd0,
		OP_TICK    = 2'd1,
		OP_SILENCE = 2'd2,
		OP_NONE    = 2'd3
	} op_e;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_PAST   = 2'd2,
		ST_NO_ADD = 2'd3
	} status_e;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_SHIFT_L,
		CELL_INSERT
	} cell_act_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_DROP,
		S_EXEC,
		S_REPORT
	} state_e;

	typedef struct packed {
		logic [1:0]        operation;
		logic [TIME_W-1:0] time_now;
		logic [TIME_W-1:0] alarm_time;
	} alarm_in_t;

	typedef struct packed {
		logic [1:0]           status;
		logic                 fired;
		logic [TIME_W-1:0]    fired_time;
		logic [OUT_CNT_W-1:0] alarm_count;
		logic                 ringing;
		logic [TIME_W-1:0]    next_alarm;
	} alarm_out_t;

	typedef struct packed {
		cell_act_e         act;
		logic [TIME_W-1:0] key;
		logic [CNT_W-1:0]  count;
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/satq_cell.sv
// One slot of the sorted alarm table.
// Holds one time, compares it with the insert key and trades times with its neighbors.
// Depends on satq_pkg.
`default_nettype none

module satq_cell
	import satq_pkg::*;
(
	input  wire logic              clk,
	input  wire cell_ctrl_t        ctrl,
	input  wire logic [IDX_W-1:0]  idx,
	input  wire logic [TIME_W-1:0] left_time,
	input  wire logic              left_gt,
	input  wire logic [TIME_W-1:0] right_time,
	output logic [TIME_W-1:0]      time_q,
	output logic                   gt
);

	logic occupied;
	logic at_count;

	assign occupied = CNT_W'(idx) < ctrl.count;
	assign at_count = CNT_W'(idx) == ctrl.count;
	assign gt       = occupied && (time_q > ctrl.key);

	always_ff @(posedge clk) begin
		unique case (ctrl.act)
			CELL_SHIFT_L: begin
				time_q <= right_time;
			end
			CELL_INSERT: begin
				if (left_gt) begin
					time_q <= left_time;
				end else if (gt || at_count) begin
					time_q <= ctrl.key;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/satq_ctrl.sv
// Sequencer of the sorted alarm queue: command transfer, expiry sweep, insert, fire and silence.
// Drives the cell row and builds the result.
// Depends on satq_pkg.
`default_nettype none

module satq_ctrl
	import satq_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire alarm_in_t         cmd,
	input  wire logic [TIME_W-1:0] head_time,
	output logic                   busy,
	output cell_ctrl_t             cell_ctrl,
	output logic                   done,
	output alarm_out_t             result
);

	state_e            state_q, state_d;
	op_e               op_q;
	logic [TIME_W-1:0] now_q;
	logic [TIME_W-1:0] key_q;
	logic [CNT_W-1:0]  count_q;
	logic              ring_q;
	status_e           status_q;
	logic              fired_q;
	logic [TIME_W-1:0] fired_time_q;
	logic              done_q;
	alarm_out_t        res_q;

	logic head_valid, expired, can_fire, full, add_ok;

	assign head_valid = count_q != '0;
	assign expired    = head_valid && (head_time <= now_q);
	assign can_fire   = !ring_q && head_valid && (now_q > head_time);
	assign full       = count_q == CNT_W'(TABLE_DEPTH);
	assign add_ok     = (key_q > now_q) && !full;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (op_e'(cmd.operation) == OP_ADD) ? S_DROP : S_EXEC;
				end
			end
			S_DROP: begin
				if (!expired) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_REPORT;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cell_ctrl.act   = CELL_HOLD;
		cell_ctrl.key   = key_q;
		cell_ctrl.count = count_q;
		priority if (state_q == S_DROP && expired) begin
			cell_ctrl.act = CELL_SHIFT_L;
		end else if (state_q == S_EXEC && op_q == OP_ADD && add_ok) begin
			cell_ctrl.act = CELL_INSERT;
		end else if (state_q == S_EXEC && op_q == OP_TICK && can_fire) begin
			cell_ctrl.act = CELL_SHIFT_L;
		end else begin
			cell_ctrl.act = CELL_HOLD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ring_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= state_q == S_REPORT;
			if (state_q == S_DROP && expired) begin
				count_q <= count_q - 1'b1;
			end
			if (state_q == S_EXEC) begin
				unique case (op_q)
					OP_ADD: begin
						if (add_ok) begin
							count_q <= count_q + 1'b1;
						end
					end
					OP_TICK: begin
						if (can_fire) begin
							count_q <= count_q - 1'b1;
							ring_q  <= 1'b1;
						end
					end
					OP_SILENCE: begin
						ring_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q  <= op_e'(cmd.operation);
			now_q <= cmd.time_now;
			key_q <= cmd.alarm_time;
		end
		if (state_q == S_EXEC) begin
			fired_q      <= 1'b0;
			fired_time_q <= '0;
			status_q     <= ST_NO_ADD;
			if (op_q == OP_ADD) begin
				priority if (key_q <= now_q) begin
					status_q <= ST_PAST;
				end else if (full) begin
					status_q <= ST_FULL;
				end else begin
					status_q <= ST_OK;
				end
			end else if (op_q == OP_TICK && can_fire) begin
				fired_q      <= 1'b1;
				fired_time_q <= head_time;
			end
		end
		if (state_q == S_REPORT) begin
			res_q.status      <= status_q;
			res_q.fired       <= fired_q;
			res_q.fired_time  <= fired_time_q;
			res_q.alarm_count <= OUT_CNT_W'(count_q);
			res_q.ringing     <= ring_q;
			res_q.next_alarm  <= head_valid ? head_time : '0;
		end
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = res_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("pending count above table depth");

	a_done_after_report: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q) == S_REPORT)
		else $error("result strobe without report cycle");

	a_ring_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ring_q) |-> $past(state_q) == S_EXEC && $past(op_q) == OP_TICK)
		else $error("ringing set outside a tick");

	a_ok_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && res_q.status == ST_OK |-> res_q.alarm_count != '0)
		else $error("insert reported with empty table");

endmodule

`default_nettype wire

FILE: rtl/sorted_alarm_time_queue_top.sv
// Top level of the sorted alarm time queue.
// Instantiates satq_ctrl and a row of TABLE_DEPTH satq_cell slots; depends on satq_pkg.
//
// Usage:
//   Command channel: present cmd with start high; the transfer happens at a rising
//   edge where start is high and busy is low. Busy stays high until the command is done.
//   Result channel: done pulses for one cycle with result valid in that cycle; the
//   receiver cannot stall it, and the next command may be taken while it is shown.
//   Tick, silence and unused operations go from transfer through the execute and
//   report states to the done cycle. An add first passes a drop state, where the
//   cell row shifts left by one slot per cycle while the head is expired (its time
//   not later than time_now), and then inserts in the execute state.
//   Reset (arst_n low) empties the table and clears ringing; slot contents are
//   not cleared and are never read before being written.
`default_nettype none

module sorted_alarm_time_queue_top
	import satq_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      start,
	input  wire alarm_in_t cmd,
	output logic           busy,
	output logic           done,
	output alarm_out_t     result
);

	cell_ctrl_t        cell_ctrl;
	logic [TIME_W-1:0] slot_time [TABLE_DEPTH];
	logic              slot_gt   [TABLE_DEPTH];

	satq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.cmd       (cmd),
		.head_time (slot_time[0]),
		.busy      (busy),
		.cell_ctrl (cell_ctrl),
		.done      (done),
		.result    (result)
	);

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		logic [TIME_W-1:0] left_time;
		logic              left_gt;
		logic [TIME_W-1:0] right_time;

		if (i == 0) begin : g_first
			assign left_time = '0;
			assign left_gt   = 1'b0;
		end else begin : g_mid
			assign left_time = slot_time[i-1];
			assign left_gt   = slot_gt[i-1];
		end

		if (i == TABLE_DEPTH - 1) begin : g_last
			assign right_time = '0;
		end else begin : g_inner
			assign right_time = slot_time[i+1];
		end

		satq_cell u_cell (
			.clk        (clk),
			.ctrl       (cell_ctrl),
			.idx        (IDX_W'(i)),
			.left_time  (left_time),
			.left_gt    (left_gt),
			.right_time (right_time),
			.time_q     (slot_time[i]),
			.gt         (slot_gt[i])
		);
	end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for sorted_alarm_time_queue_top.
// Runs a directed table, then random alarm sessions checked against an in-bench predictor.
// Depends on satq_pkg and the RTL of the sorted alarm time queue.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import satq_pkg::*;

	localparam logic [TIME_W-1:0] TMAX = {TIME_W{1'b1}};
	localparam int N_ROWS = 23;
	localparam int N_ITEMS = 1500;

	typedef struct packed {
		alarm_in_t  c;
		logic       fixed;
		alarm_out_t r;
	} stim_row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	alarm_in_t  cmd = '0;
	logic       busy;
	logic       done;
	alarm_out_t result;

	logic [TIME_W-1:0] model_times [TABLE_DEPTH];
	int                model_count = 0;
	logic              model_ringing = 1'b0;

	alarm_out_t alarm_results_due [$];
	stim_row_t  stim_rows [N_ROWS];
	int         mismatches = 0;
	int         items_sent = 0;
	int         gap_pct = 0;

	sorted_alarm_time_queue_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic alarm_in_t mk_cmd(op_e op, logic [TIME_W-1:0] now, logic [TIME_W-1:0] at);
		alarm_in_t c;
		c.operation  = op;
		c.time_now   = now;
		c.alarm_time = at;
		return c;
	endfunction

	function automatic stim_row_t pred_row(op_e op, logic [TIME_W-1:0] now,
			logic [TIME_W-1:0] at);
		stim_row_t s;
		s.c     = mk_cmd(op, now, at);
		s.fixed = 1'b0;
		s.r     = '0;
		return s;
	endfunction

	function automatic stim_row_t fixed_row(op_e op, logic [TIME_W-1:0] now,
			logic [TIME_W-1:0] at, status_e st, logic f, logic [TIME_W-1:0] ft,
			logic [OUT_CNT_W-1:0] cnt, logic rg, logic [TIME_W-1:0] nx);
		stim_row_t s;
		s.c             = mk_cmd(op, now, at);
		s.fixed         = 1'b1;
		s.r.status      = st;
		s.r.fired       = f;
		s.r.fired_time  = ft;
		s.r.alarm_count = cnt;
		s.r.ringing     = rg;
		s.r.next_alarm  = nx;
		return s;
	endfunction

	function automatic logic [TIME_W-1:0] later(logic [TIME_W-1:0] t, int unsigned d);
		logic [31:0] s;
		s = {1'b0, t} + d;
		return (s > {1'b0, TMAX}) ? TMAX : s[TIME_W-1:0];
	endfunction

	function automatic logic [TIME_W-1:0] earlier(logic [TIME_W-1:0] t, int unsigned d);
		return (t > d) ? TIME_W'(t - d) : '0;
	endfunction

	function automatic alarm_out_t predict_alarm_result(alarm_in_t c);
		alarm_out_t r;
		int i;
		int kept;
		int pos;
		r = '0;
		r.status = ST_NO_ADD;
		case (c.operation)
			OP_ADD: begin
				kept = 0;
				for (i = 0; i < model_count; i++) begin
					if (model_times[i] > c.time_now) begin
						model_times[kept] = model_times[i];
						kept++;
					end
				end
				model_count = kept;
				if (c.alarm_time <= c.time_now) begin
					r.status = ST_PAST;
				end else if (model_count >= TABLE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = 0;
					while (pos < model_count && model_times[pos] <= c.alarm_time)
						pos++;
					for (i = model_count; i > pos; i--)
						model_times[i] = model_times[i-1];
					model_times[pos] = c.alarm_time;
					model_count++;
					r.status = ST_OK;
				end
			end
			OP_TICK: begin
				if (!model_ringing && model_count > 0 && c.time_now > model_times[0]) begin
					r.fired       = 1'b1;
					r.fired_time  = model_times[0];
					model_ringing = 1'b1;
					for (i = 1; i < model_count; i++)
						model_times[i-1] = model_times[i];
					model_count--;
				end
			end
			OP_SILENCE: begin
				model_ringing = 1'b0;
			end
			default: begin
			end
		endcase
		r.alarm_count = model_count[OUT_CNT_W-1:0];
		r.ringing     = model_ringing;
		r.next_alarm  = (model_count > 0) ? model_times[0] : '0;
		return r;
	endfunction

	task automatic send_item(input alarm_in_t c, input alarm_out_t exp);
		start <= 1'b1;
		cmd   <= c;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		alarm_results_due.push_back(exp);
		items_sent++;
		if ($urandom_range(0, 99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	task automatic issue(input op_e op, input logic [TIME_W-1:0] now,
			input logic [TIME_W-1:0] at);
		alarm_in_t c;
		c = mk_cmd(op, now, at);
		send_item(c, predict_alarm_result(c));
	endtask

	task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
		if (a !== e) begin
			$error("%s: expected %0h, got %0h", name, e, a);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin : result_check
		alarm_out_t exp;
		if (arst_n && done === 1'b1) begin
			if (alarm_results_due.size() == 0) begin
				$error("result transfer with nothing due: %0h", result);
				mismatches++;
			end else begin
				exp = alarm_results_due.pop_front();
				check_field("status", 32'(exp.status), 32'(result.status));
				check_field("fired", 32'(exp.fired), 32'(result.fired));
				check_field("fired_time", 32'(exp.fired_time), 32'(result.fired_time));
				check_field("alarm_count", 32'(exp.alarm_count), 32'(result.alarm_count));
				check_field("ringing", 32'(exp.ringing), 32'(result.ringing));
				check_field("next_alarm", 32'(exp.next_alarm), 32'(result.next_alarm));
			end
		end
	end

	initial begin
		#4_000_000;
		$display("sorted_alarm_time_queue_top test failed");
		$finish;
	end

	initial begin
		int                row;
		int                j;
		int                len;
		int                pick;
		int                drain;
		alarm_out_t        exp;
		logic [TIME_W-1:0] clock_s;
		logic [TIME_W-1:0] at;

		stim_rows = '{
			fixed_row(OP_TICK, 0, 0, ST_NO_ADD, 0, 0, 0, 0, 0),
			fixed_row(OP_NONE, TMAX, TMAX, ST_NO_ADD, 0, 0, 0, 0, 0),
			fixed_row(OP_SILENCE, TMAX, 0, ST_NO_ADD, 0, 0, 0, 0, 0),
			fixed_row(OP_ADD, TMAX, TMAX, ST_PAST, 0, 0, 0, 0, 0),
			fixed_row(OP_ADD, 0, 0, ST_PAST, 0, 0, 0, 0, 0),
			fixed_row(OP_ADD, 0, TMAX, ST_OK, 0, 0, 1, 0, TMAX),
			fixed_row(OP_ADD, 0, 100, ST_OK, 0, 0, 2, 0, 100),
			pred_row(OP_ADD, 0, 100),
			pred_row(OP_ADD, 1, 50),
			fixed_row(OP_TICK, 50, 0, ST_NO_ADD, 0, 0, 4, 0, 50),
			fixed_row(OP_TICK, 51, 0, ST_NO_ADD, 1, 50, 3, 1, 100),
			pred_row(OP_TICK, TMAX, TMAX),
			pred_row(OP_SILENCE, 0, 0),
			pred_row(OP_TICK, 101, 0),
			pred_row(OP_NONE, 101, 0),
			pred_row(OP_SILENCE, 5, TMAX),
			pred_row(OP_ADD, 100, 150),
			pred_row(OP_ADD, TMAX - TIME_W'(1), 0),
			pred_row(OP_TICK, TMAX, 0),
			fixed_row(OP_ADD, TMAX, 5, ST_PAST, 0, 0, 0, 0, 0),
			pred_row(OP_ADD, 0, 1),
			pred_row(OP_TICK, 2, TMAX),
			pred_row(OP_SILENCE, TMAX, TMAX)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		gap_pct = 30;
		for (row = 0; row < N_ROWS; row++) begin
			exp = predict_alarm_result(stim_rows[row].c);
			if (stim_rows[row].fixed)
				exp = stim_rows[row].r;
			send_item(stim_rows[row].c, exp);
		end

		clock_s = '0;
		while (items_sent < N_ROWS + N_ITEMS) begin
			if (items_sent > N_ROWS + N_ITEMS - 150)
				gap_pct = 0;
			else
				case ($urandom_range(0, 2))
					0: gap_pct = 0;
					1: gap_pct = 15;
					default: gap_pct = 50;
				endcase
			pick = $urandom_range(0, 9);
			if (pick < 5) begin
				case ($urandom_range(0, 9))
					0: clock_s = TIME_W'($urandom);
					1: clock_s = TIME_W'(TMAX - $urandom_range(0, 500));
					default: clock_s = later(clock_s, $urandom_range(0, 40));
				endcase
				len = $urandom_range(10, 40);
				for (j = 0; j < len; j++) begin
					pick = $urandom_range(0, 99);
					if (pick < 45) begin
						if ($urandom_range(0, 9) == 0)
							at = earlier(clock_s, $urandom_range(0, 30));
						else
							at = later(clock_s, $urandom_range(1, 80));
						issue(OP_ADD, clock_s, at);
					end else if (pick < 85) begin
						clock_s = later(clock_s, $urandom_range(0, 25));
						issue(OP_TICK, clock_s, TIME_W'($urandom));
					end else begin
						issue(OP_SILENCE, clock_s, TIME_W'($urandom));
					end
				end
			end else if (pick < 7) begin
				len = $urandom_range(60, 75);
				for (j = 0; j < len; j++)
					issue(OP_ADD, clock_s, later(clock_s, $urandom_range(1, 200)));
				for (j = 0; j < 10; j++) begin
					clock_s = later(clock_s, $urandom_range(0, 30));
					issue(OP_TICK, clock_s, TIME_W'($urandom));
					issue(OP_SILENCE, clock_s, TIME_W'($urandom));
				end
			end else if (pick < 8) begin
				clock_s = later(clock_s, $urandom_range(100, 3000));
				issue(OP_ADD, clock_s, later(clock_s, $urandom_range(0, 100)));
			end else begin
				len = $urandom_range(5, 15);
				for (j = 0; j < len; j++)
					issue(op_e'($urandom_range(0, 3)), TIME_W'($urandom), TIME_W'($urandom));
			end
		end
		start <= 1'b0;

		drain = 0;
		while (alarm_results_due.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (80) @(posedge clk);
		if (alarm_results_due.size() != 0) begin
			$error("%0d results never arrived", alarm_results_due.size());
			mismatches++;
		end

		if (mismatches == 0)
			$display("sorted_alarm_time_queue_top test passed");
		else
			$display("sorted_alarm_time_queue_top test failed");
		$finish;
	end

endmodule

`default_nettype wire
